// File: hdl/dpdd_pkg.sv
package dpdd_pkg;

	// Field widths of one request
	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;

	// Day ordinal of the largest year that fits the year field
	localparam int ORD_W  = 23;
	// Day offset inside one year (up to 366)
	localparam int OFF_W  = 9;
	localparam int DIFF_W = 22;
	localparam logic [DIFF_W-1:0] DIFF_MAX = '1;

	localparam logic [MON_W-1:0] MONTHS = 4'd12;
	localparam logic [MON_W-1:0] FEB    = 4'd2;

	// Floor division by 100 as multiply and shift; exact for operands below 43690
	localparam int DIV100_MUL_W = 13;
	localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
	localparam int DIV100_SHIFT = 19;
	localparam int CENT_W = YEAR_W + DIV100_MUL_W - DIV100_SHIFT;

	typedef enum logic [1:0] {
		ORD_FIRST_LATER  = 2'd0,
		ORD_SECOND_LATER = 2'd1,
		ORD_EQUAL        = 2'd2
	} order_t;

	typedef struct packed {
		logic [DAY_W-1:0]  first_day;
		logic [MON_W-1:0]  first_month;
		logic [YEAR_W-1:0] first_year;
		logic [DAY_W-1:0]  second_day;
		logic [MON_W-1:0]  second_month;
		logic [YEAR_W-1:0] second_year;
	} req_t;

	typedef struct packed {
		logic              first_valid;
		logic              second_valid;
		order_t            order;
		logic [DIFF_W-1:0] day_difference;
	} res_t;

	// Per-stage load enables for the date datapath
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
	                                               input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:    len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [OFF_W-1:0] days_before(input logic [MON_W-1:0] m);
		logic [OFF_W-1:0] n;
		unique case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

// File: hdl/dpdd_date.sv
module dpdd_date #(
	parameter int YEAR_MAX = 9999
) (
	input  logic                       clk,
	input  dpdd_pkg::stage_en_t        en,
	input  logic [dpdd_pkg::DAY_W-1:0]  day,
	input  logic [dpdd_pkg::MON_W-1:0]  month,
	input  logic [dpdd_pkg::YEAR_W-1:0] year,
	output logic                       ok,
	output logic [dpdd_pkg::ORD_W-1:0]  ordinal
);
	import dpdd_pkg::*;

	localparam int PROD_W = YEAR_W + DIV100_MUL_W;

	// Stage 1: previous year, its centuries, range checks
	logic [YEAR_W-1:0] prev_year;
	logic [PROD_W-1:0] cent_prod;
	logic              yok_c, mok_c;

	assign prev_year = year - YEAR_W'(1);
	assign cent_prod = PROD_W'(prev_year) * PROD_W'(DIV100_MUL);
	assign yok_c     = (year != '0) && (32'(year) <= 32'(YEAR_MAX));
	assign mok_c     = (month != '0) && (month <= MONTHS);

	logic [DAY_W-1:0]  day_s1;
	logic [MON_W-1:0]  month_s1;
	logic [YEAR_W-1:0] prev_s1;
	logic [CENT_W-1:0] cent_s1;
	logic              yok_s1, mok_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			day_s1   <= day;
			month_s1 <= month;
			prev_s1  <= prev_year;
			cent_s1  <= cent_prod[DIV100_SHIFT +: CENT_W];
			yok_s1   <= yok_c;
			mok_s1   <= mok_c;
		end
	end

	// Stage 2: leap rule, day check, days before the year and inside it
	logic [YEAR_W-1:0] rem100;
	logic              cent_year, leap, dok;
	logic [1:0]        year_lo;
	logic [DAY_W-1:0]  mlen;
	logic [ORD_W-1:0]  base_c;
	logic [OFF_W-1:0]  off_c;

	assign rem100    = prev_s1 - YEAR_W'(YEAR_W'(cent_s1) * YEAR_W'(100));
	// year divisible by 100 exactly when the previous year ends in 99
	assign cent_year = (rem100 == YEAR_W'(99));
	assign year_lo   = prev_s1[1:0] + 2'd1;
	// centuries of the year itself are cent_s1 + 1 here
	assign leap      = ((year_lo == 2'd0) && !cent_year)
	                 || (cent_year && (cent_s1[1:0] == 2'b11));
	assign mlen      = month_len(month_s1, leap);
	assign dok       = (day_s1 != '0) && (day_s1 <= mlen);

	assign base_c = ORD_W'(prev_s1) * ORD_W'(365) + ORD_W'(prev_s1 >> 2)
	              - ORD_W'(cent_s1) + ORD_W'(cent_s1 >> 2);
	assign off_c  = days_before(month_s1)
	              + OFF_W'((month_s1 > FEB) && leap) + OFF_W'(day_s1);

	logic [ORD_W-1:0] base_s2;
	logic [OFF_W-1:0] off_s2;
	logic             ok_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			base_s2 <= base_c;
			off_s2  <= off_c;
			ok_s2   <= yok_s1 && mok_s1 && dok;
		end
	end

	// Stage 3: final ordinal
	logic [ORD_W-1:0] ord_s3;
	logic             ok_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ord_s3 <= base_s2 + ORD_W'(off_s2);
			ok_s3  <= ok_s2;
		end
	end

	assign ok      = ok_s3;
	assign ordinal = ord_s3;

endmodule

// File: hdl/date_pair_day_difference_top.sv
// Gregorian date pair day difference.
// Throughput: one request per cycle while not stalled; the date ordinals
// run in a 3-stage pipe (s1 to s3), the difference sits in the output register
// (s4) before result_valid, and bubbles close up on stall.
// Reset: arst_n clears all stage valid bits asynchronously; data is not reset.
module date_pair_day_difference_top #(
	parameter int YEAR_MAX = 9999
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           dates_valid,
	output logic           dates_stall,
	input  dpdd_pkg::req_t dates,
	output logic           result_valid,
	input  logic           result_stall,
	output dpdd_pkg::res_t result
);
	import dpdd_pkg::*;

	logic      v_s1, v_s2, v_s3, v_s4;
	logic      rdy1, rdy2, rdy3, rdy4;
	stage_en_t en;

	// Each stage loads when it is empty or its successor moves
	assign rdy4 = !v_s4 || !result_stall;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign en   = '{s1: rdy1, s2: rdy2, s3: rdy3};

	assign dates_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= dates_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Order from the raw fields: year, then month, then day
	logic [YEAR_W+MON_W+DAY_W-1:0] key1, key2;
	order_t                        ord_c;

	assign key1 = {dates.first_year, dates.first_month, dates.first_day};
	assign key2 = {dates.second_year, dates.second_month, dates.second_day};

	always_comb begin
		priority if (key1 > key2) ord_c = ORD_FIRST_LATER;
		else if (key1 < key2)     ord_c = ORD_SECOND_LATER;
		else                      ord_c = ORD_EQUAL;
	end

	order_t ord_s1, ord_s2, ord_s3;

	always_ff @(posedge clk) begin
		if (rdy1) ord_s1 <= ord_c;
		if (rdy2) ord_s2 <= ord_s1;
		if (rdy3) ord_s3 <= ord_s2;
	end

	// Day ordinals of both dates
	logic             ok1, ok2;
	logic [ORD_W-1:0] o1, o2;

	dpdd_date #(.YEAR_MAX(YEAR_MAX)) u_first (
		.clk     (clk),
		.en      (en),
		.day     (dates.first_day),
		.month   (dates.first_month),
		.year    (dates.first_year),
		.ok      (ok1),
		.ordinal (o1)
	);

	dpdd_date #(.YEAR_MAX(YEAR_MAX)) u_second (
		.clk     (clk),
		.en      (en),
		.day     (dates.second_day),
		.month   (dates.second_month),
		.year    (dates.second_year),
		.ok      (ok2),
		.ordinal (o2)
	);

	// Stage 4: absolute difference, saturate, zero on an invalid date
	logic [ORD_W-1:0]  ord_gap;
	logic [DIFF_W-1:0] diff_c;

	assign ord_gap = (o1 >= o2) ? (o1 - o2) : (o2 - o1);

	always_comb begin
		priority if (!ok1 || !ok2)             diff_c = '0;
		else if (ord_gap > ORD_W'(DIFF_MAX))   diff_c = DIFF_MAX;
		else                                   diff_c = DIFF_W'(ord_gap);
	end

	res_t res_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			res_s4.first_valid    <= ok1;
			res_s4.second_valid   <= ok2;
			res_s4.order          <= ord_s3;
			res_s4.day_difference <= diff_c;
		end
	end

	assign result_valid = v_s4;
	assign result       = res_s4;

endmodule

// File: hdl/dpdd_checker.sv
module dpdd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           result_valid,
	input logic           result_stall,
	input dpdd_pkg::res_t result
);
	import dpdd_pkg::*;

	// A stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result does not change
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	// Invalid dates give no distance
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (!result.first_valid || !result.second_valid)
		|-> result.day_difference == '0)
		else $error("nonzero difference with an invalid date");

	// Equal dates are the same day
	a_equal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.order == ORD_EQUAL)
		|-> (result.day_difference == '0)
		    && (result.first_valid == result.second_valid))
		else $error("equal dates disagree");

	// Two valid distinct dates are at least a day apart
	a_distinct_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.first_valid && result.second_valid
		&& (result.order != ORD_EQUAL) |-> result.day_difference != '0)
		else $error("distinct valid dates with zero difference");

endmodule

bind date_pair_day_difference_top dpdd_checker u_dpdd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// File: test/tb_date_pair_day_difference_top.sv
module tb_date_pair_day_difference_top;
	import dpdd_pkg::req_t;
	import dpdd_pkg::res_t;
	import dpdd_pkg::ORD_FIRST_LATER;
	import dpdd_pkg::ORD_SECOND_LATER;
	import dpdd_pkg::ORD_EQUAL;
	import dpdd_pkg::FEB;
	import dpdd_pkg::MONTHS;

	localparam int YEAR_LIMIT = 9999;
	localparam int DAYS_SATURATE = 4194303;
	localparam int RANDOM_PAIRS = 1200;
	// Pipe is 4 deep; leave slack after the last result
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
	} cal_date_t;

	logic clk;
	logic arst_n = 1'b0;
	logic dates_valid = 1'b0;
	logic dates_stall;
	req_t dates = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	res_t result;

	// Results predicted for accepted requests, oldest first
	res_t expected_results[$];

	int fail_count = 0;
	int pairs_sent = 0;
	int pairs_both_valid = 0;
	int results_checked = 0;

	// Idling knobs, changed per phase
	int gap_max = 0;
	int burst_max = 1;
	int burst_left = 0;
	int stall_pct = 0;
	int stall_run = 0;
	logic stall_state = 1'b0;

	date_pair_day_difference_top #(
		.YEAR_MAX(YEAR_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.dates_valid(dates_valid),
		.dates_stall(dates_stall),
		.dates(dates),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Calendar arithmetic
	function automatic bit leap_year(input int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int month_days(input int m, input int y);
		if (m == FEB) begin
			return leap_year(y) ? 29 : 28;
		end
		case (m)
			4, 6, 9, 11: return 30;
			1, 3, 5, 7, 8, 10, 12: return 31;
			default: return 0;
		endcase
	endfunction

	function automatic bit date_exists(input cal_date_t c);
		if (c.year < 1 || c.year > YEAR_LIMIT) begin
			return 1'b0;
		end
		if (c.month < 1 || c.month > MONTHS) begin
			return 1'b0;
		end
		return (c.day >= 1) && (c.day <= month_days(c.month, c.year));
	endfunction

	// 1 Jan of year 1 counts as day 1
	function automatic int day_ordinal(input cal_date_t c);
		int p;
		int n;
		int k;
		p = int'(c.year) - 1;
		n = p * 365 + p / 4 - p / 100 + p / 400 + int'(c.day);
		for (k = 1; k < c.month; k++) begin
			n += month_days(k, c.year);
		end
		return n;
	endfunction

	function automatic res_t predict_result(input req_t r);
		res_t e;
		cal_date_t a;
		cal_date_t b;
		logic [22:0] key_a;
		logic [22:0] key_b;
		int diff;
		a.day = r.first_day;
		a.month = r.first_month;
		a.year = r.first_year;
		b.day = r.second_day;
		b.month = r.second_month;
		b.year = r.second_year;
		e.first_valid = date_exists(a);
		e.second_valid = date_exists(b);
		// Order compares raw fields: year, then month, then day
		key_a = {a.year, a.month, a.day};
		key_b = {b.year, b.month, b.day};
		if (key_a > key_b) begin
			e.order = ORD_FIRST_LATER;
		end else if (key_a < key_b) begin
			e.order = ORD_SECOND_LATER;
		end else begin
			e.order = ORD_EQUAL;
		end
		diff = 0;
		if (e.first_valid && e.second_valid) begin
			diff = day_ordinal(a) - day_ordinal(b);
			if (diff < 0) begin
				diff = -diff;
			end
			if (diff > DAYS_SATURATE) begin
				diff = DAYS_SATURATE;
			end
		end
		e.day_difference = diff[21:0];
		return e;
	endfunction

	// Stimulus helpers
	function automatic cal_date_t on_day(input int d, input int m, input int y);
		cal_date_t c;
		c.day = d[4:0];
		c.month = m[3:0];
		c.year = y[13:0];
		return c;
	endfunction

	function automatic req_t date_pair(input cal_date_t a, input cal_date_t b);
		req_t r;
		r.first_day = a.day;
		r.first_month = a.month;
		r.first_year = a.year;
		r.second_day = b.day;
		r.second_month = b.month;
		r.second_year = b.year;
		return r;
	endfunction

	function automatic cal_date_t random_real_date();
		int y;
		int m;
		case ($urandom_range(0, 7))
			0: y = 100 * $urandom_range(1, YEAR_LIMIT / 100);
			1: y = $urandom_range(0, 1) ? 1 : YEAR_LIMIT;
			2: y = $urandom_range(1, 60);
			default: y = $urandom_range(1, YEAR_LIMIT);
		endcase
		m = $urandom_range(1, 12);
		return on_day($urandom_range(1, month_days(m, y)), m, y);
	endfunction

	function automatic cal_date_t random_raw_date();
		return on_day($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
	endfunction

	// Sender: bursts of random length, random gaps between them
	task automatic send_dates(input req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, burst_max);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				@(negedge clk);
				dates_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		dates <= r;
		dates_valid <= 1'b1;
		@(posedge clk);
		while (dates_stall) @(posedge clk);
	endtask

	// Receiver stall pattern: random runs of stall or no stall
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_state = ($urandom_range(0, 99) < stall_pct);
			stall_run = $urandom_range(1, 6);
		end
		stall_run--;
		result_stall <= stall_state;
	end

	// Predict on every accepted request
	always @(posedge clk) begin
		if (arst_n && dates_valid && !dates_stall) begin
			expected_results.push_back(predict_result(dates));
			pairs_sent++;
			if (date_exists(on_day(dates.first_day, dates.first_month, dates.first_year)) &&
			    date_exists(on_day(dates.second_day, dates.second_month, dates.second_year))) begin
				pairs_both_valid++;
			end
		end
	end

	// Compare every accepted result with the oldest prediction
	always @(posedge clk) begin
		res_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding: %p", result);
				fail_count++;
			end else begin
				e = expected_results.pop_front();
				results_checked++;
				if (result.first_valid !== e.first_valid) begin
					$error("first_valid: expected %0d, got %0d", e.first_valid, result.first_valid);
					fail_count++;
				end
				if (result.second_valid !== e.second_valid) begin
					$error("second_valid: expected %0d, got %0d", e.second_valid,
					       result.second_valid);
					fail_count++;
				end
				if (result.order !== e.order) begin
					$error("order: expected %0d, got %0d", e.order, result.order);
					fail_count++;
				end
				if (result.day_difference !== e.day_difference) begin
					$error("day_difference: expected %0d, got %0d", e.day_difference,
					       result.day_difference);
					fail_count++;
				end
			end
		end
	end

	// Calendar limits and largest raw field values
	task automatic test_extremes();
		send_dates(date_pair(on_day(1, 1, 1), on_day(31, 12, YEAR_LIMIT)));
		send_dates(date_pair(on_day(31, 12, YEAR_LIMIT), on_day(1, 1, 1)));
		send_dates(date_pair(on_day(31, 12, YEAR_LIMIT), on_day(31, 12, YEAR_LIMIT)));
		send_dates(date_pair(on_day(31, 15, 16383), on_day(31, 15, 16383)));
		send_dates(date_pair(on_day(0, 0, 0), on_day(0, 0, 0)));
		send_dates(date_pair(on_day(31, 15, 16383), on_day(1, 1, 1)));
	endtask

	// Each way a date can fail to exist, with the order still reported
	task automatic test_invalid_dates();
		send_dates(date_pair(on_day(0, 5, 2000), on_day(1, 5, 2000)));
		send_dates(date_pair(on_day(10, 0, 2000), on_day(10, 1, 2000)));
		send_dates(date_pair(on_day(10, 13, 2000), on_day(10, 12, 2000)));
		send_dates(date_pair(on_day(1, 1, 0), on_day(1, 1, 1)));
		send_dates(date_pair(on_day(1, 1, 1), on_day(1, 1, YEAR_LIMIT + 1)));
		send_dates(date_pair(on_day(31, 4, 2021), on_day(30, 4, 2021)));
		send_dates(date_pair(on_day(30, 2, 2000), on_day(1, 3, 2000)));
	endtask

	// Leap rule: every 4th year, not centuries, except every 400th
	task automatic test_leap_rule();
		send_dates(date_pair(on_day(29, 2, 2000), on_day(1, 3, 1999)));
		send_dates(date_pair(on_day(29, 2, 1900), on_day(28, 2, 1900)));
		send_dates(date_pair(on_day(29, 2, 2004), on_day(29, 2, 2100)));
		send_dates(date_pair(on_day(28, 2, 2024), on_day(1, 3, 2024)));
		send_dates(date_pair(on_day(1, 3, 1900), on_day(28, 2, 1900)));
		send_dates(date_pair(on_day(29, 2, 400), on_day(29, 2, 1600)));
	endtask

	// Dates within one year, one month, across a year boundary, and identical dates
	task automatic test_same_year();
		send_dates(date_pair(on_day(5, 3, 2021), on_day(20, 11, 2021)));
		send_dates(date_pair(on_day(20, 11, 2021), on_day(5, 11, 2021)));
		send_dates(date_pair(on_day(14, 7, 1789), on_day(14, 7, 1789)));
		send_dates(date_pair(on_day(31, 12, 1), on_day(1, 1, 2)));
	endtask

	// Mostly real dates, with raw noise and near-miss invalid dates mixed in
	task automatic test_random_pairs(input int count);
		cal_date_t a;
		cal_date_t b;
		int i;
		for (i = 0; i < count; i++) begin
			if (i % 150 == 0) begin
				case ((i / 150) % 4)
					0: begin gap_max = 0; burst_max = 1; stall_pct = 0; end
					1: begin gap_max = 6; burst_max = 8; stall_pct = 0; end
					2: begin gap_max = 0; burst_max = 1; stall_pct = 60; end
					default: begin gap_max = 4; burst_max = 5; stall_pct = 35; end
				endcase
			end
			a = random_real_date();
			case ($urandom_range(0, 9))
				0, 1, 2, 3: b = random_real_date();
				4: begin
					b.year = a.year;
					b.month = 4'($urandom_range(1, 12));
					b.day = 5'($urandom_range(1, month_days(b.month, b.year)));
				end
				5: begin
					b = a;
					b.day = 5'($urandom_range(1, month_days(b.month, b.year)));
				end
				6: b = a;
				7: b = random_raw_date();
				8: begin
					a = random_raw_date();
					b = random_raw_date();
				end
				default: begin
					b = a;
					b.day = 5'(month_days(b.month, b.year) + 1);
				end
			endcase
			if ($urandom_range(0, 1)) begin
				send_dates(date_pair(a, b));
			end else begin
				send_dates(date_pair(b, a));
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		gap_max = 3;
		burst_max = 4;
		stall_pct = 30;
		test_extremes();
		test_invalid_dates();
		test_leap_rule();
		test_same_year();
		test_random_pairs(RANDOM_PAIRS);

		@(negedge clk);
		dates_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d date pairs (%0d with both dates real), checked %0d results,",
		         pairs_sent, pairs_both_valid, results_checked);
		$display("under sender gaps and receiver stalls in alternating phases.");
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(12 * 500000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
